// ===== rtl/eti_pkg.sv =====
// Edge timing fault injector: shared types, register indexes and constants.
// Used by eti_rem_unit, eti_csr and edge_timing_fault_injector_core.
// No dependencies.
package eti_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned RemWidth      = 32;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] RegDropPeriod  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegDupPeriod   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegDupSpacing  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegFixedDelay  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegJitterRange = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegRandomSeed  = 3'd5;

   // LCG coefficients
   localparam logic [31:0] LcgMul = 32'd1664525;
   localparam logic [31:0] LcgAdd = 32'd1013904223;

   typedef struct packed {
      logic [15:0] drop_period;
      logic [15:0] duplicate_period;
      logic [31:0] duplicate_spacing;
      logic [31:0] fixed_delay;
      logic [29:0] jitter_range;
      logic [31:0] random_seed;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_stat_type;

endpackage

// ===== rtl/eti_rem_unit.sv =====
// Shared restoring remainder unit, one quotient bit per cycle.
// Depends on eti_pkg.
module eti_rem_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [eti_pkg::RemWidth-1:0]   dividend,
   input  logic [eti_pkg::RemWidth-1:0]   divisor,   // must be nonzero
   output eti_pkg::rem_stat_type          stat,
   output logic [eti_pkg::RemWidth-1:0]   remainder
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [4:0]                     cnt_ff, cnt_in;
   logic [eti_pkg::RemWidth-1:0]   dvd_ff, dvd_in;
   logic [eti_pkg::RemWidth-1:0]   dsr_ff, dsr_in;
   logic [eti_pkg::RemWidth-1:0]   rem_ff, rem_in;
   logic [eti_pkg::RemWidth:0]     trial;
   logic [eti_pkg::RemWidth:0]     diff;

   assign trial = {rem_ff, dvd_ff[eti_pkg::RemWidth-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // trial subtract; keep the difference when it does not go negative
         rem_in = diff[eti_pkg::RemWidth] ? trial[eti_pkg::RemWidth-1:0]
                                          : diff[eti_pkg::RemWidth-1:0];
         dvd_in = {dvd_ff[eti_pkg::RemWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/eti_csr.sv =====
// Configuration register file for the edge timing fault injector.
// Depends on eti_pkg.
module eti_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [eti_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [eti_pkg::CsrDataWidth-1:0]   csr_wdata,
   output eti_pkg::cfg_type                   cfg
);

   eti_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            eti_pkg::RegDropPeriod:  cfg_in.drop_period       = csr_wdata[15:0];
            eti_pkg::RegDupPeriod:   cfg_in.duplicate_period  = csr_wdata[15:0];
            eti_pkg::RegDupSpacing:  cfg_in.duplicate_spacing = csr_wdata;
            eti_pkg::RegFixedDelay:  cfg_in.fixed_delay       = csr_wdata;
            eti_pkg::RegJitterRange: cfg_in.jitter_range      = csr_wdata[29:0];
            eti_pkg::RegRandomSeed:  cfg_in.random_seed       = csr_wdata;
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/edge_timing_fault_injector_core.sv =====
// Edge timing fault injector, top level: sequencer, LCG and time datapath.
// Depends on eti_pkg, eti_rem_unit and eti_csr.
//
//  channel  | direction | transaction
//  ---------+-----------+------------------------------------------------------
//  req_*    | in        | one scripted edge: time, level, start mark (tuser)
//  rsp_*    | out       | nothing, the edge, or edge and duplicate; tuser = duplicate copy
//  csr_*    | in        | register write: index, 32-bit data
//
// Sequence: an accepted edge passes the drop check, the LCG step, jitter and
// the duplicate check, then sum, clamp and its results. Each enabled modulo
// (drop check, jitter, duplicate check) runs on the shared 32-step remainder
// unit; a dropped edge goes back to idle after its drop check.
// req_tready is high only while the sequencer is idle; a result waits in
// the output register under rsp_tvalid, and a stalled rsp side holds the
// sequencer. Reset: synchronous; count to 0, generator to 1, registers to 0.
module edge_timing_fault_injector_core (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [61:0] edge_time, [62] edge_level, [63] zero
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,
   // req_tuser: [0] script_start
   input  logic                               req_tuser,
   // rsp_tdata: [62:0] out_time, [63] out_level
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [63:0]                        rsp_tdata,
   // rsp_tuser: [0] is_duplicate
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [eti_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [eti_pkg::CsrDataWidth-1:0]   csr_wdata
);

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DROP_GO   = 4'd1;
   localparam logic [3:0] S_DROP_WAIT = 4'd2;
   localparam logic [3:0] S_LCG       = 4'd3;
   localparam logic [3:0] S_JIT_GO    = 4'd4;
   localparam logic [3:0] S_JIT_WAIT  = 4'd5;
   localparam logic [3:0] S_DUP_GO    = 4'd6;
   localparam logic [3:0] S_DUP_WAIT  = 4'd7;
   localparam logic [3:0] S_SUM       = 4'd8;
   localparam logic [3:0] S_CLAMP     = 4'd9;
   localparam logic [3:0] S_OUT1      = 4'd10;
   localparam logic [3:0] S_OUT2      = 4'd11;

   eti_pkg::cfg_type       cfg;
   eti_pkg::rem_stat_type  rem_stat;
   logic                   rem_start;
   logic [31:0]            rem_dividend;
   logic [31:0]            rem_divisor;
   logic [31:0]            rem_value;

   logic [3:0]   state_ff, state_in;
   logic [31:0]  count_ff, count_in;     // edges since start mark
   logic [31:0]  gen_ff, gen_in;         // LCG state
   logic [63:0]  base_ff, base_in;       // edge time + fixed delay (signed)
   logic         level_ff, level_in;
   logic [32:0]  jit_ff, jit_in;         // signed jitter offset
   logic         dup_ff, dup_in;
   logic [63:0]  sum_ff, sum_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [62:0]  rsp_time_ff, rsp_time_in;
   logic         rsp_level_ff, rsp_level_in;
   logic         rsp_dup_ff, rsp_dup_in;
   logic         rsp_last_ff, rsp_last_in;

   logic         req_fire;
   logic         rsp_fire;
   logic         jit_on;
   logic [31:0]  seed_eff;

   eti_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   eti_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (rem_divisor),
      .stat      (rem_stat),
      .remainder (rem_value)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_valid_ff & rsp_tready;
   assign jit_on     = (cfg.jitter_range != '0);
   assign seed_eff   = (cfg.random_seed == '0) ? 32'd1 : cfg.random_seed;

   // operand select for the shared remainder unit, held through the wait
   always_comb begin
      rem_start    = 1'b0;
      rem_dividend = count_ff;
      rem_divisor  = {16'd0, cfg.drop_period};
      case (state_ff)
         S_DROP_GO, S_DROP_WAIT: begin
            rem_start   = (state_ff == S_DROP_GO);
         end
         S_JIT_GO, S_JIT_WAIT: begin
            rem_start    = (state_ff == S_JIT_GO);
            rem_dividend = gen_ff;
            rem_divisor  = {1'b0, cfg.jitter_range, 1'b1};   // 2J+1
         end
         S_DUP_GO, S_DUP_WAIT: begin
            rem_start   = (state_ff == S_DUP_GO);
            rem_divisor = {16'd0, cfg.duplicate_period};
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      gen_in       = gen_ff;
      base_in      = base_ff;
      level_in     = level_ff;
      jit_in       = jit_ff;
      dup_in       = dup_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_level_in = rsp_level_ff;
      rsp_dup_in   = rsp_dup_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // start mark restarts the count and reloads the generator
               if (req_tuser) begin
                  count_in = 32'd1;
                  gen_in   = seed_eff;
               end else begin
                  count_in = count_ff + 32'd1;
               end
               base_in  = {2'b00, req_tdata[61:0]}
                        + {{32{cfg.fixed_delay[31]}}, cfg.fixed_delay};
               level_in = req_tdata[62];
               state_in = (cfg.drop_period != '0) ? S_DROP_GO : S_LCG;
            end
         end
         S_DROP_GO: state_in = S_DROP_WAIT;
         S_DROP_WAIT: begin
            if (rem_stat.done) begin
               // dropped edge: counted, no result, generator untouched
               state_in = (rem_value == '0) ? S_IDLE : S_LCG;
            end
         end
         S_LCG: begin
            if (jit_on) begin
               gen_in   = gen_ff * eti_pkg::LcgMul + eti_pkg::LcgAdd;
               state_in = S_JIT_GO;
            end else begin
               jit_in   = '0;
               state_in = (cfg.duplicate_period != '0) ? S_DUP_GO : S_SUM;
               dup_in   = 1'b0;
            end
         end
         S_JIT_GO: state_in = S_JIT_WAIT;
         S_JIT_WAIT: begin
            if (rem_stat.done) begin
               jit_in   = {1'b0, rem_value} - {3'b000, cfg.jitter_range};
               dup_in   = 1'b0;
               state_in = (cfg.duplicate_period != '0) ? S_DUP_GO : S_SUM;
            end
         end
         S_DUP_GO: state_in = S_DUP_WAIT;
         S_DUP_WAIT: begin
            if (rem_stat.done) begin
               dup_in   = (rem_value == '0);
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            sum_in   = base_ff + {{31{jit_ff[32]}}, jit_ff};
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            // negative time clamps to zero
            rsp_time_in  = sum_ff[63] ? '0 : sum_ff[62:0];
            rsp_level_in = level_ff;
            rsp_dup_in   = 1'b0;
            rsp_last_in  = ~dup_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT1;
         end
         S_OUT1: begin
            if (rsp_fire) begin
               if (dup_ff) begin
                  // duplicate copy: cannot overflow 63 bits
                  rsp_time_in = rsp_time_ff + {31'd0, cfg.duplicate_spacing};
                  rsp_dup_in  = 1'b1;
                  rsp_last_in = 1'b1;
                  state_in    = S_OUT2;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end
         S_OUT2: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         gen_ff       <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff      <= base_in;
      level_ff     <= level_in;
      jit_ff       <= jit_in;
      dup_ff       <= dup_in;
      sum_ff       <= sum_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_level_ff <= rsp_level_in;
      rsp_dup_ff   <= rsp_dup_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_level_ff, rsp_time_ff};
   assign rsp_tuser  = rsp_dup_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // no new edge is taken while a result is pending
   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_tready)
      else $error("edge accepted while a result is pending");

   // a duplicate copy always closes the run
   a_dup_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dup_ff) |-> rsp_last_ff)
      else $error("duplicate copy not marked last");

   // a first result without tlast is followed by its duplicate copy
   a_dup_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_last_ff) |=> (rsp_valid_ff && rsp_dup_ff))
      else $error("missing duplicate after non-final result");

   // remainder unit result is below its divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_stat.done |-> (rem_value < rem_divisor))
      else $error("remainder not below divisor");

   // remainder unit only runs in a wait state
   a_rem_busy_state: assert property (@(posedge clock) disable iff (reset)
      rem_stat.busy |-> (state_ff == S_DROP_WAIT || state_ff == S_JIT_WAIT
                         || state_ff == S_DUP_WAIT))
      else $error("remainder unit busy outside a wait state");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for edge_timing_fault_injector_core: scripted edges in,
// predicted drop/delay/jitter/duplicate results compared transaction by transaction.
// Depends on eti_pkg and the RTL of the core.
module testbench;

   // Spare register indexes: writes to them must change nothing
   localparam logic [eti_pkg::CsrIndexWidth-1:0] RegSpareA = 3'd6;
   localparam logic [eti_pkg::CsrIndexWidth-1:0] RegSpareB = 3'd7;
   localparam logic [61:0] TimeMax = 62'h3FFF_FFFF_FFFF_FFFF;
   localparam int unsigned SettleCycles = 150;   // exceeds the time a dropped edge needs to finish

   typedef struct packed {
      logic [62:0] out_time;
      logic        out_level;
      logic        is_dup;
      logic        last;
   } edge_result_type;

   // Predictor of the injector plus the queue of edges still owed by the block
   class scoreboard_type;
      eti_pkg::cfg_type regs;
      logic [31:0]      edge_count;
      logic [31:0]      lcg_state;
      edge_result_type  owed_q[$];
      int               errors;
      int               edges_in;
      int               checked;
      int               dropped;
      int               duplicated;

      function new();
         regs       = '0;
         edge_count = 32'd0;
         lcg_state  = 32'd1;
      endfunction

      function void note_write(logic [eti_pkg::CsrIndexWidth-1:0] idx, logic [31:0] data);
         case (idx)
            eti_pkg::RegDropPeriod:  regs.drop_period       = data[15:0];
            eti_pkg::RegDupPeriod:   regs.duplicate_period  = data[15:0];
            eti_pkg::RegDupSpacing:  regs.duplicate_spacing = data;
            eti_pkg::RegFixedDelay:  regs.fixed_delay       = data;
            eti_pkg::RegJitterRange: regs.jitter_range      = data[29:0];
            eti_pkg::RegRandomSeed:  regs.random_seed       = data;
            default: ;
         endcase
      endfunction

      function void note_edge(logic [61:0] t_in, logic lvl, logic start);
         logic signed [63:0] moved;
         logic [31:0]        span;
         logic [31:0]        rem;
         logic [62:0]        out_t;
         bit                 dup;
         edge_result_type    r;
         edges_in++;
         if (start) begin
            edge_count = 32'd0;
            lcg_state  = (regs.random_seed == 32'd0) ? 32'd1 : regs.random_seed;
         end
         edge_count = edge_count + 32'd1;
         // dropped edges still count but leave the generator alone
         if (regs.drop_period != 16'd0
             && edge_count % {16'd0, regs.drop_period} == 32'd0) begin
            dropped++;
            return;
         end
         moved = $signed({2'b00, t_in})
               + $signed({{32{regs.fixed_delay[31]}}, regs.fixed_delay});
         if (regs.jitter_range != 30'd0) begin
            lcg_state = lcg_state * eti_pkg::LcgMul + eti_pkg::LcgAdd;
            span      = {1'b0, regs.jitter_range, 1'b1};
            rem       = lcg_state % span;
            moved     = moved + $signed({32'd0, rem}) - $signed({34'd0, regs.jitter_range});
         end
         if (moved < 0)
            moved = 64'sd0;
         out_t = moved[62:0];
         dup   = regs.duplicate_period != 16'd0
                 && edge_count % {16'd0, regs.duplicate_period} == 32'd0;
         r = '{out_time: out_t, out_level: lvl, is_dup: 1'b0, last: !dup};
         owed_q.insert(owed_q.size(), r);
         if (dup) begin
            duplicated++;
            r = '{out_time: out_t + {31'd0, regs.duplicate_spacing}, out_level: lvl,
                  is_dup: 1'b1, last: 1'b1};
            owed_q.insert(owed_q.size(), r);
         end
      endfunction

      function void check_result(logic [62:0] t, logic lvl, logic dup, logic last);
         edge_result_type exp_r;
         if (owed_q.size() == 0) begin
            $error("result with nothing expected: time %0d level %0b", t, lvl);
            errors++;
            return;
         end
         exp_r = owed_q.pop_front();
         checked++;
         if (t !== exp_r.out_time) begin
            $error("out_time: expected %0d, got %0d", exp_r.out_time, t);
            errors++;
         end
         if (lvl !== exp_r.out_level) begin
            $error("out_level: expected %0b, got %0b", exp_r.out_level, lvl);
            errors++;
         end
         if (dup !== exp_r.is_dup) begin
            $error("is_duplicate: expected %0b, got %0b", exp_r.is_dup, dup);
            errors++;
         end
         if (last !== exp_r.last) begin
            $error("last_of_run: expected %0b, got %0b", exp_r.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [eti_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [eti_pkg::CsrDataWidth-1:0]  csr_wdata = '0;

   scoreboard_type sb = new();

   // Idle pressure, changed per phase; 0 gives stretches with no gaps at all
   int gap_pct   = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int settings_used = 0;

   edge_timing_fault_injector_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly short idles, now and then a long one
   function automatic int idle_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(20, 120);
      return $urandom_range(1, 4);
   endfunction

   // Result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= idle_len() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result monitor: rsp_tdata = {out_level, out_time}, tuser = duplicate copy
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[62:0], rsp_tdata[63], rsp_tuser, rsp_tlast);
   end

   // One edge transaction; tvalid stays high when the next edge follows at once
   task automatic send_edge(logic [61:0] t, logic lvl, logic start);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < gap_pct)
         gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, lvl, t};
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      sb.note_edge(t, lvl, start);
   endtask

   // Register write; csr_valid is left high for back-to-back writes
   task automatic csr_write(logic [eti_pkg::CsrIndexWidth-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.note_write(idx, data);
   endtask

   task automatic apply_settings(logic [31:0] drop, logic [31:0] dup, logic [31:0] spacing,
                                 logic [31:0] delay, logic [31:0] jitter, logic [31:0] seed);
      csr_write(eti_pkg::RegDropPeriod, drop);
      csr_write(eti_pkg::RegDupPeriod, dup);
      csr_write(eti_pkg::RegDupSpacing, spacing);
      csr_write(eti_pkg::RegFixedDelay, delay);
      csr_write(eti_pkg::RegJitterRange, jitter);
      csr_write(eti_pkg::RegRandomSeed, seed);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Let every owed result arrive, then give a dropped edge time to finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_period();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = 32'd0;
         3:       v = 32'd65535;
         4:       v = $urandom_range(0, 65535);
         default: v = $urandom_range(1, 8);
      endcase
      // junk above bit 15 must be ignored
      if ($urandom_range(0, 3) == 0)
         v[31:16] = 16'($urandom);
      return v;
   endfunction

   task automatic random_settings();
      logic [31:0] spacing;
      logic [31:0] delay;
      logic [31:0] jitter;
      logic [31:0] seed;
      case ($urandom_range(0, 3))
         0:       spacing = 32'd0;
         1:       spacing = 32'hFFFF_FFFF;
         2:       spacing = $urandom;
         default: spacing = $urandom_range(1, 10000);
      endcase
      case ($urandom_range(0, 5))
         0:       delay = 32'd0;
         1:       delay = 32'h8000_0000;
         2:       delay = 32'h7FFF_FFFF;
         3:       delay = $urandom;
         default: delay = $urandom_range(0, 20000) - 10000;
      endcase
      case ($urandom_range(0, 4))
         0:       jitter = 32'd0;
         1:       jitter = 32'h3FFF_FFFF;
         2:       jitter = $urandom;        // upper two bits are ignored
         default: jitter = $urandom_range(1, 500);
      endcase
      case ($urandom_range(0, 3))
         0:       seed = 32'd0;
         1:       seed = 32'hFFFF_FFFF;
         default: seed = $urandom;
      endcase
      apply_settings(pick_period(), pick_period(), spacing, delay, jitter, seed);
   endtask

   function automatic logic [61:0] rand_time();
      logic [63:0] v;
      case ($urandom_range(0, 7))
         0:       v = 64'($urandom_range(0, 1000));
         1:       v = {2'b00, TimeMax - 62'($urandom_range(0, 1000))};
         default: v = {$urandom, $urandom};
      endcase
      return v[61:0];
   endfunction

   // Mostly proper scripts (start mark, rising times, alternating level),
   // with some stray edges mixed in
   task automatic random_phase(int n_items);
      int          sent;
      int          run_len;
      logic [61:0] t;
      logic        lvl;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) < 8) begin
            run_len = $urandom_range(3, 20);
            case ($urandom_range(0, 3))
               0:       t = 62'($urandom_range(0, 5000));
               1:       t = TimeMax - 62'd200000;
               default: t = 62'({$urandom, $urandom} >> 3);
            endcase
            lvl = 1'($urandom_range(0, 1));
            for (int i = 0; i < run_len && sent < n_items; i++) begin
               send_edge(t, lvl, i == 0);
               t   = t + 62'($urandom_range(1, 5000));
               lvl = ~lvl;
               sent++;
            end
         end else begin
            send_edge(rand_time(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, first edges without a start mark: count from zero, generator at one
      send_edge(62'd0, 1'b0, 1'b0);
      send_edge(TimeMax, 1'b1, 1'b0);
      send_edge(62'd12345, 1'b1, 1'b1);
      settle();

      // Drop every third, duplicate every second, widest jitter, most negative
      // delay (clamp at zero), zero seed taken as one, largest spacing
      apply_settings(32'd3, 32'd2, 32'hFFFF_FFFF, 32'h8000_0000, 32'h3FFF_FFFF, 32'd0);
      send_edge(62'd0, 1'b1, 1'b1);
      send_edge(62'd1, 1'b0, 1'b0);
      send_edge(62'd2, 1'b1, 1'b0);
      send_edge(TimeMax, 1'b0, 1'b0);
      send_edge(62'h0000_0000_8000_0000, 1'b1, 1'b0);
      send_edge(62'h0000_0000_4000_0000, 1'b0, 1'b0);
      settle();

      // Drop everything: no results at all
      apply_settings(32'd1, 32'd1, 32'd7, 32'd0, 32'd5, 32'd9);
      send_edge(62'd100, 1'b1, 1'b1);
      send_edge(62'd200, 1'b0, 1'b0);
      settle();

      // Duplicate everything, largest positive delay, no jitter, spacing zero;
      // spare register indexes must not disturb anything
      csr_write(RegSpareA, 32'hFFFF_FFFF);
      csr_write(RegSpareB, 32'hA5A5_5A5A);
      apply_settings(32'd0, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      send_edge(TimeMax, 1'b1, 1'b0);
      send_edge(62'd0, 1'b0, 1'b0);
      send_edge(62'd42, 1'b1, 1'b1);
      settle();

      // Largest periods, delay of minus one into the clamp, jitter of one
      apply_settings(32'd65535, 32'd65535, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd1);
      send_edge(62'd0, 1'b1, 1'b1);
      send_edge(62'd1, 1'b0, 1'b0);
      send_edge(62'd2, 1'b1, 1'b0);
      settle();

      // Random part: fresh settings and idle pressure per phase
      for (int p = 0; p < 10; p++) begin
         random_settings();
         case (p % 4)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 30; stall_pct = 20; end
            2:       begin gap_pct = 10; stall_pct = 60; end
            default: begin gap_pct = 60; stall_pct = 5;  end
         endcase
         random_phase(54);
         settle();
      end

      $display("Ran %0d edges through %0d register settings: %0d results checked,",
               sb.edges_in, settings_used, sb.checked);
      $display("%0d edges dropped and %0d duplicated.", sb.dropped, sb.duplicated);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #15_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/eti_pkg.sv
rtl/eti_rem_unit.sv
rtl/eti_csr.sv
rtl/edge_timing_fault_injector_core.sv
verif/testbench.sv
